FILE: src/ssp_pkg.sv
package ssp_pkg;

	// parse phase of the front end
	typedef enum logic [2:0] {
		PH_DIGITS,
		PH_UNIT,
		PH_UNIT_I,
		PH_DONE,
		PH_ERR
	} phase_t;

	// result status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NO_DIGITS  = 3'd1;
	localparam logic [2:0] ST_NUM_OVF    = 3'd2;
	localparam logic [2:0] ST_ODD_NIBBLE = 3'd3;
	localparam logic [2:0] ST_BAD_UNIT   = 3'd4;
	localparam logic [2:0] ST_SCALE_OVF  = 3'd5;

	// queue depth between front and back
	localparam int QDEPTH = 2;

	// one finished text, handed from front to back
	typedef struct packed {
		logic [63:0] accum;     // number before scaling
		logic [2:0]  steps;     // unit exponent, scaling steps left
		logic        base_two;  // 1024 steps instead of 1000
		logic [2:0]  status;    // status known at the front, ST_OK if scaling decides
		logic [6:0]  position;  // position to report when no scaling error
	} job_t;

endpackage

FILE: src/size_suffix_parser_top.sv
// Channel   Direction  Word fields (low bit first)
// s_*       in         tdata[7:0] text_char, tlast is_last
// m_*       out        tdata[63:0] size_value, tdata[70:64] position, tuser[2:0] status
// apb       in/out     0x0 size_limit (64 bits, reset all ones)
//
// One character is taken every cycle; the front end never waits on the scaler
// unless the two-entry job queue is full.
// Results pass the job queue, the scaler and its output register. The scaler
// takes u steps, u being the unit exponent (0 to 6), and one text at a time.
// Reset clears all control state at once; there is no clearing pass.
// A stalled output holds its word while the front parses until the queue fills.
module size_suffix_parser_top
	import ssp_pkg::*;
#(
	parameter int MAX_CHARS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_char
	input  logic        s_tlast,   // is_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [63:0] size_value, [70:64] position, [71] zero
	output logic [2:0]  m_tuser,   // [2:0] status
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic        push, q_full, pop, q_avail;
	job_t        push_job, q_head;
	logic [63:0] size_limit_q;
	logic [63:0] value;
	logic [6:0]  position;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[3] == 1'b0) ? size_limit_q : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_limit_q <= '1;
		end else if (psel && penable && pwrite && pready && paddr[3] == 1'b0) begin
			size_limit_q <= pwdata;
		end
	end

	ssp_front #(.MAX_CHARS(MAX_CHARS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_char  (s_tdata),
		.in_last  (s_tlast),
		.push     (push),
		.push_job (push_job),
		.q_full   (q_full)
	);

	ssp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.avail    (q_avail),
		.head     (q_head)
	);

	ssp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.size_limit   (size_limit_q),
		.q_avail      (q_avail),
		.q_head       (q_head),
		.pop          (pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_value    (value),
		.out_status   (m_tuser),
		.out_position (position)
	);

	assign m_tdata = {1'b0, position, value};

endmodule

FILE: src/ssp_front.sv
module ssp_front
	import ssp_pkg::*;
#(
	parameter int MAX_CHARS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       in_last,
	output logic       push,
	output job_t       push_job,
	input  logic       q_full
);

	localparam int CW = $clog2(MAX_CHARS + 1);

	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UZ = 8'h5A;
	localparam logic [7:0] CH_N  = 8'h6E;
	localparam logic [7:0] CH_B  = 8'h62;
	localparam logic [7:0] CH_I  = 8'h69;
	localparam logic [7:0] CH_K  = 8'h6B;
	localparam logic [7:0] CH_M  = 8'h6D;
	localparam logic [7:0] CH_G  = 8'h67;
	localparam logic [7:0] CH_T  = 8'h74;
	localparam logic [7:0] CH_P  = 8'h70;
	localparam logic [7:0] CH_E  = 8'h65;

	localparam logic [2:0] UNIT_NONE    = 3'd0;
	localparam logic [2:0] UNIT_UNKNOWN = 3'd7;

	function automatic logic [2:0] letter_code(input logic [7:0] ch);
		logic [2:0] code;
		unique case (ch)
			CH_K:    code = 3'd1;
			CH_M:    code = 3'd2;
			CH_G:    code = 3'd3;
			CH_T:    code = 3'd4;
			CH_P:    code = 3'd5;
			CH_E:    code = 3'd6;
			default: code = UNIT_UNKNOWN;
		endcase
		return code;
	endfunction

	phase_t          phase_q, phase_n;
	logic [63:0]     accum_q, accum_n;
	logic [2:0]      unit_q, unit_n;
	logic            base_two_q, base_two_n;
	logic [CW-1:0]   consumed_q, consumed_n;
	logic [2:0]      err_q, err_n;

	logic            accept;
	logic            is_digit;
	logic [7:0]      lc;
	logic [67:0]     acc_x10;
	logic            num_ovf;
	logic [CW-1:0]   cons_inc;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// character decode and the shift-add for the next decimal digit
	assign is_digit = (in_char >= CH_0) && (in_char <= CH_9);
	assign lc       = ((in_char >= CH_UA) && (in_char <= CH_UZ)) ? in_char + 8'd32 : in_char;
	assign acc_x10  = ({4'd0, accum_q} << 3) + ({4'd0, accum_q} << 1)
	                + {60'd0, in_char - CH_0};
	assign num_ovf  = acc_x10[67:64] != 4'd0;
	assign cons_inc = (consumed_q < CW'(MAX_CHARS)) ? consumed_q + CW'(1) : consumed_q;

	// next phase
	always_comb begin
		phase_n = phase_q;
		unique case (phase_q)
			PH_DIGITS: begin
				priority if (is_digit) begin
					if (num_ovf) phase_n = PH_ERR;
				end else if (consumed_q == '0) begin
					phase_n = PH_ERR;
				end else if (in_char == 8'd0) begin
					phase_n = PH_DONE;
				end else if (lc == CH_N) begin
					phase_n = accum_q[0] ? PH_ERR : PH_DONE;
				end else if (lc == CH_B) begin
					phase_n = PH_DONE;
				end else begin
					phase_n = PH_UNIT;
				end
			end
			PH_UNIT:   phase_n = (lc == CH_I) ? PH_UNIT_I : PH_DONE;
			PH_UNIT_I: phase_n = PH_DONE;
			PH_DONE:   phase_n = PH_DONE;
			PH_ERR:    phase_n = PH_ERR;
			default:   phase_n = PH_ERR;
		endcase
	end

	// parse datapath
	always_comb begin
		accum_n    = accum_q;
		unit_n     = unit_q;
		base_two_n = base_two_q;
		consumed_n = consumed_q;
		err_n      = err_q;
		unique case (phase_q)
			PH_DIGITS: begin
				priority if (is_digit) begin
					if (num_ovf) begin
						err_n = ST_NUM_OVF;
					end else begin
						accum_n    = acc_x10[63:0];
						consumed_n = cons_inc;
					end
				end else if (consumed_q == '0) begin
					err_n = ST_NO_DIGITS;
				end else if (in_char == 8'd0) begin
					accum_n = accum_q;
				end else if (lc == CH_N) begin
					consumed_n = cons_inc;
					if (accum_q[0]) err_n = ST_ODD_NIBBLE;
					else accum_n = accum_q >> 1;
				end else if (lc == CH_B) begin
					consumed_n = cons_inc;
				end else begin
					consumed_n = cons_inc;
					unit_n     = letter_code(lc);
				end
			end
			PH_UNIT: begin
				if (lc == CH_I) begin
					base_two_n = 1'b1;
					consumed_n = cons_inc;
				end else if (lc == CH_B) begin
					consumed_n = cons_inc;
				end
			end
			PH_UNIT_I: begin
				if (lc == CH_B) consumed_n = cons_inc;
			end
			default: begin
				accum_n = accum_q;
			end
		endcase
	end

	// classify the finished text into a job for the back end
	always_comb begin
		push_job.accum    = accum_n;
		push_job.base_two = base_two_n;
		push_job.steps    = 3'd0;
		push_job.position = 7'd0;
		priority if (phase_n == PH_DIGITS && consumed_n == '0) begin
			push_job.status = ST_NO_DIGITS;
		end else if (phase_n == PH_ERR) begin
			push_job.status = err_n;
		end else if (unit_n == UNIT_UNKNOWN) begin
			push_job.status   = ST_BAD_UNIT;
			push_job.position = 7'(consumed_n);
		end else begin
			push_job.status   = ST_OK;
			push_job.steps    = unit_n;
			push_job.position = 7'(consumed_n);
		end
	end

	assign push = accept && in_last;

	// parse state, cleared after the last word of a text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_DIGITS;
			accum_q    <= '0;
			unit_q     <= UNIT_NONE;
			base_two_q <= 1'b0;
			consumed_q <= '0;
			err_q      <= ST_OK;
		end else if (accept) begin
			if (in_last) begin
				phase_q    <= PH_DIGITS;
				accum_q    <= '0;
				unit_q     <= UNIT_NONE;
				base_two_q <= 1'b0;
				consumed_q <= '0;
				err_q      <= ST_OK;
			end else begin
				phase_q    <= phase_n;
				accum_q    <= accum_n;
				unit_q     <= unit_n;
				base_two_q <= base_two_n;
				consumed_q <= consumed_n;
				err_q      <= err_n;
			end
		end
	end

endmodule

FILE: src/ssp_queue.sv
module ssp_queue
	import ssp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic avail,
	output job_t head
);

	localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int NW = $clog2(QDEPTH + 1);

	job_t          slot_q [QDEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [NW-1:0] count_q;

	assign full  = count_q == NW'(QDEPTH);
	assign avail = count_q != '0;
	assign head  = slot_q[rd_q];

	// job storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_job;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(QDEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (pop)  rd_q <= (rd_q == AW'(QDEPTH - 1)) ? '0 : rd_q + AW'(1);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + NW'(1);
				2'b01:   count_q <= count_q - NW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: src/ssp_back.sv
module ssp_back
	import ssp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] size_limit,
	input  logic        q_avail,
	input  job_t        q_head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_value,
	output logic [2:0]  out_status,
	output logic [6:0]  out_position
);

	logic        busy_q;
	job_t        job_q;
	logic        ovf_q;
	logic        finish;
	logic [73:0] ext;
	logic [73:0] scaled;

	logic        out_valid_q;
	logic [63:0] value_q;
	logic [2:0]  status_q;
	logic [6:0]  position_q;

	// one scaling step: times 1024 is a shift, times 1000 is 1024 - 16 - 8
	assign ext    = {10'd0, job_q.accum};
	assign scaled = job_q.base_two ? (ext << 10) : (ext << 10) - (ext << 4) - (ext << 3);

	assign finish = busy_q && (job_q.steps == 3'd0) && (!out_valid_q || out_ready);
	assign pop    = q_avail && (!busy_q || finish);

	// scaling loop, one step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (pop) begin
			busy_q <= 1'b1;
		end else if (finish) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_head;
			ovf_q <= 1'b0;
		end else if (busy_q && job_q.steps != 3'd0) begin
			job_q.accum <= scaled[63:0];
			job_q.steps <= job_q.steps - 3'd1;
			ovf_q       <= ovf_q || (scaled[73:64] != 10'd0);
		end
	end

	// output register, loaded on the final limit check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			priority if (job_q.status != ST_OK) begin
				value_q    <= 64'd0;
				status_q   <= job_q.status;
				position_q <= job_q.position;
			end else if (ovf_q || job_q.accum > size_limit) begin
				value_q    <= 64'd0;
				status_q   <= ST_SCALE_OVF;
				position_q <= 7'd0;
			end else begin
				value_q    <= job_q.accum;
				status_q   <= ST_OK;
				position_q <= job_q.position;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_value    = value_q;
	assign out_status   = status_q;
	assign out_position = position_q;

endmodule

FILE: src/ssp_checker.sv
module ssp_checker
	import ssp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// only defined status codes leave the block
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= ST_SCALE_OVF)
		else $error("undefined status code");

	// any error gives a zero size
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata[63:0] == 64'd0)
		else $error("nonzero size with error status");

	// errors without an offset report position zero
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_NO_DIGITS || m_tuser == ST_NUM_OVF ||
		             m_tuser == ST_ODD_NIBBLE || m_tuser == ST_SCALE_OVF)
		|-> m_tdata[71:64] == 8'd0)
		else $error("position set for an error without offset");

endmodule

bind size_suffix_parser_top ssp_checker u_ssp_checker (.*);

FILE: tb/tb_size_suffix_parser_top.sv
module tb_size_suffix_parser_top;
	import ssp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAT_CHARS = 64;
	localparam int CYCLE_LIMIT = 300000;
	// settling time for the longest scale (unit exponent 6), plus margin
	localparam int DRAIN_CYCLES = 12;
	localparam int SEG_ITEMS = 96;
	localparam logic [3:0] REG_SIZE_LIMIT = 4'h0;
	localparam logic [2:0] UNIT_NONE = 3'd0;
	localparam logic [2:0] UNIT_OTHER = 3'd7;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic [63:0] value;
		logic [2:0]  status;
		logic [6:0]  position;
	} size_res_t;

	typedef struct {
		logic [7:0]  ch;
		bit          last;
		bit          typed;
		logic [63:0] value;
		logic [2:0]  status;
		logic [6:0]  position;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] text_char
	logic        s_tlast;   // is_last
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;   // [63:0] size_value, [70:64] position, [71] zero
	logic [2:0]  m_tuser;   // [2:0] status
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	size_suffix_parser_top #(
		.MAX_CHARS(SAT_CHARS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// parser shadow state
	logic [63:0] acc_q;
	phase_t      ph_q;
	logic [2:0]  unit_q;
	logic        base2_q;
	logic [6:0]  cnt_q;
	logic [2:0]  err_q;
	logic [63:0] limit_q;

	size_res_t   pending_sizes[$];
	stim_row_t   directed_rows[$];
	logic [7:0]  text_q[$];

	int gap_pct;
	int stall_pct;
	int mismatches;
	int cycles;
	int seg_items;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run-time limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic void restart_parse();
		acc_q = '0;
		ph_q = PH_DIGITS;
		unit_q = UNIT_NONE;
		base2_q = 1'b0;
		cnt_q = '0;
		err_q = ST_OK;
	endfunction

	function automatic void bump_count();
		if (cnt_q < SAT_CHARS)
			cnt_q = cnt_q + 7'd1;
	endfunction

	function automatic void parse_fail(input logic [2:0] code);
		err_q = code;
		ph_q = PH_ERR;
	endfunction

	function automatic logic [2:0] unit_code(input logic [7:0] lc);
		case (lc)
			"k": return 3'd1;
			"m": return 3'd2;
			"g": return 3'd3;
			"t": return 3'd4;
			"p": return 3'd5;
			"e": return 3'd6;
			default: return UNIT_OTHER;
		endcase
	endfunction

	// expected behavior for one accepted word; returns 1 when a result follows
	function automatic bit parse_char(input logic [7:0] ch, input bit last,
			output size_res_t res);
		logic [7:0]   lc;
		logic [67:0]  grown;
		logic [63:0]  mult;
		logic [127:0] scaled;
		lc = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
		res.value = '0;
		res.status = ST_OK;
		res.position = '0;
		case (ph_q)
			PH_DIGITS: begin
				if (ch >= "0" && ch <= "9") begin
					grown = {4'b0, acc_q} * 68'd10 + {60'b0, ch - 8'h30};
					if (grown[67:64] != 4'd0) begin
						parse_fail(ST_NUM_OVF);
					end else begin
						acc_q = grown[63:0];
						bump_count();
					end
				end else if (cnt_q == 0) begin
					parse_fail(ST_NO_DIGITS);
				end else if (ch == 8'h00) begin
					ph_q = PH_DONE;
				end else if (lc == "n") begin
					bump_count();
					if (acc_q[0]) begin
						parse_fail(ST_ODD_NIBBLE);
					end else begin
						acc_q = acc_q >> 1;
						ph_q = PH_DONE;
					end
				end else if (lc == "b") begin
					bump_count();
					ph_q = PH_DONE;
				end else begin
					bump_count();
					unit_q = unit_code(lc);
					ph_q = PH_UNIT;
				end
			end
			PH_UNIT: begin
				if (lc == "i") begin
					base2_q = 1'b1;
					bump_count();
					ph_q = PH_UNIT_I;
				end else begin
					if (lc == "b")
						bump_count();
					ph_q = PH_DONE;
				end
			end
			PH_UNIT_I: begin
				if (lc == "b")
					bump_count();
				ph_q = PH_DONE;
			end
			default: ;
		endcase
		if (!last)
			return 1'b0;
		if (ph_q == PH_DIGITS && cnt_q == 0) begin
			res.status = ST_NO_DIGITS;
		end else if (ph_q == PH_ERR) begin
			res.status = err_q;
		end else if (unit_q == UNIT_OTHER) begin
			res.status = ST_BAD_UNIT;
			res.position = cnt_q;
		end else begin
			mult = 64'd1;
			for (int k = 0; k < unit_q; k++)
				mult = mult * (base2_q ? 64'd1024 : 64'd1000);
			scaled = {64'b0, acc_q} * {64'b0, mult};
			if (scaled[127:64] != 64'd0 || scaled[63:0] > limit_q) begin
				res.status = ST_SCALE_OVF;
			end else begin
				res.value = scaled[63:0];
				res.position = cnt_q;
			end
		end
		restart_parse();
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at cycle %0d: %s", cycles, what);
	endtask

	// offer one input word, with random idle cycles before it
	task automatic push_char(input logic [7:0] ch, input bit last);
		bit taken;
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		s_tlast <= last;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end
		seg_items++;
	endtask

	task automatic send_text();
		size_res_t res;
		for (int i = 0; i < text_q.size(); i++) begin
			push_char(text_q[i], i == text_q.size() - 1);
			if (parse_char(text_q[i], i == text_q.size() - 1, res))
				pending_sizes.push_back(res);
		end
	endtask

	// wait until every result is out, then let the scaler settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_sizes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
		bit done;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		done = 1'b0;
		while (!done) begin
			@(negedge clk);
			done = pready;
			@(posedge clk);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == REG_SIZE_LIMIT)
			limit_q = data;
	endtask

	task automatic add_row(input logic [7:0] ch, input bit last, input bit typed,
			input logic [63:0] value, input logic [2:0] status, input logic [6:0] position);
		stim_row_t r;
		r.ch = ch;
		r.last = last;
		r.typed = typed;
		r.value = value;
		r.status = status;
		r.position = position;
		directed_rows.push_back(r);
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endtask

	function automatic logic [7:0] rand_case(input logic [7:0] lc);
		return $urandom_range(1) ? lc - 8'd32 : lc;
	endfunction

	// build one random size text into text_q
	task automatic build_text();
		int pick;
		int n;
		text_q.delete();
		pick = $urandom_range(99);
		if (pick < 22) begin
			// noise: raw bytes of any value
			n = $urandom_range(1, 6);
			repeat (n) text_q.push_back(8'($urandom_range(255)));
			return;
		end
		// number part
		pick = $urandom_range(99);
		if (pick < 5) begin
			repeat ($urandom_range(58, 72)) text_q.push_back("0");
			repeat ($urandom_range(1, 3)) text_q.push_back(8'h30 + 8'($urandom_range(9)));
		end else if (pick < 8) begin
			if ($urandom_range(1))
				add_str("18446744073709551615");
			else
				add_str("18446744073709551616");
		end else if (pick < 14) begin
			text_q.push_back("1");
			repeat ($urandom_range(17, 19)) text_q.push_back(8'h30 + 8'($urandom_range(9)));
		end else begin
			n = ($urandom_range(4) == 0) ? $urandom_range(1, 9) : $urandom_range(1, 4);
			repeat (n) text_q.push_back(8'h30 + 8'($urandom_range(9)));
		end
		// suffix part
		pick = $urandom_range(99);
		if (pick < 15) begin
			;
		end else if (pick < 27) begin
			text_q.push_back(rand_case("n"));
		end else if (pick < 37) begin
			text_q.push_back(rand_case("b"));
		end else if (pick < 88) begin
			case ($urandom_range(5))
				0: text_q.push_back(rand_case("k"));
				1: text_q.push_back(rand_case("m"));
				2: text_q.push_back(rand_case("g"));
				3: text_q.push_back(rand_case("t"));
				4: text_q.push_back(rand_case("p"));
				default: text_q.push_back(rand_case("e"));
			endcase
			if ($urandom_range(1))
				text_q.push_back(rand_case("i"));
			if ($urandom_range(1))
				text_q.push_back(rand_case("b"));
		end else begin
			// random unit byte from 1 to 255, usually an unknown symbol; optional i and b
			text_q.push_back(8'($urandom_range(1, 255)));
			if ($urandom_range(2) == 0)
				text_q.push_back(rand_case("i"));
			if ($urandom_range(2) == 0)
				text_q.push_back(rand_case("b"));
		end
		// optional terminator and trailing bytes, ignored once the number has ended
		if ($urandom_range(2) == 0)
			text_q.push_back($urandom_range(1) ? 8'h00 : 8'($urandom_range(255)));
		repeat ($urandom_range(2) == 0 ? $urandom_range(1, 3) : 0)
			text_q.push_back(8'($urandom_range(255)));
	endtask

	// receiver back-pressure
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	// result check against the oldest expectation
	always @(negedge clk) begin : chk_out
		size_res_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_sizes.size() == 0) begin
				report_mismatch($sformatf("unexpected word value=%0h status=%0d pos=%0d",
					m_tdata[63:0], m_tuser, m_tdata[70:64]));
			end else begin
				exp_r = pending_sizes.pop_front();
				if (m_tdata[63:0] !== exp_r.value)
					report_mismatch($sformatf("size_value exp %0h got %0h",
						exp_r.value, m_tdata[63:0]));
				if (m_tuser !== exp_r.status)
					report_mismatch($sformatf("status exp %0d got %0d",
						exp_r.status, m_tuser));
				if (m_tdata[70:64] !== exp_r.position)
					report_mismatch($sformatf("position exp %0d got %0d",
						exp_r.position, m_tdata[70:64]));
			end
		end
	end

	initial begin : main
		int gap_sched[4];
		int stall_sched[4];
		size_res_t res;
		stim_row_t r;
		gap_sched = '{0, 57, 0, 37};
		stall_sched = '{0, 0, 57, 37};
		mismatches = 0;
		seg_items = 0;
		gap_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		limit_q = ALL_ONES;
		restart_parse();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: one word per row, last-marked rows may carry a typed result
		add_row("7", 1, 1, 64'd7, ST_OK, 7'd1);
		add_row("x", 1, 1, 64'd0, ST_NO_DIGITS, 7'd0);
		add_row(8'h00, 1, 1, 64'd0, ST_NO_DIGITS, 7'd0);
		add_row("4", 0, 0, 0, 0, 0);
		add_row("k", 1, 1, 64'd4000, ST_OK, 7'd2);
		add_row("2", 0, 0, 0, 0, 0);
		add_row("K", 0, 0, 0, 0, 0);
		add_row("i", 0, 0, 0, 0, 0);
		add_row("B", 1, 1, 64'd2048, ST_OK, 7'd4);
		// word after the suffix is ignored
		add_row("3", 0, 0, 0, 0, 0);
		add_row("m", 0, 0, 0, 0, 0);
		add_row("B", 0, 0, 0, 0, 0);
		add_row("?", 1, 1, 64'd3000000, ST_OK, 7'd3);
		add_row("5", 0, 0, 0, 0, 0);
		add_row("n", 1, 1, 64'd0, ST_ODD_NIBBLE, 7'd0);
		add_row("6", 0, 0, 0, 0, 0);
		add_row("N", 1, 1, 64'd3, ST_OK, 7'd2);
		// terminating digit is not counted
		add_row("9", 0, 0, 0, 0, 0);
		add_row("e", 0, 0, 0, 0, 0);
		add_row("9", 1, 0, 0, 0, 0);
		add_row("2", 0, 0, 0, 0, 0);
		add_row("E", 0, 0, 0, 0, 0);
		add_row("i", 1, 0, 0, 0, 0);
		add_row("8", 0, 0, 0, 0, 0);
		add_row("z", 0, 0, 0, 0, 0);
		add_row(8'hFF, 1, 1, 64'd0, ST_BAD_UNIT, 7'd2);
		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			push_char(r.ch, r.last);
			if (parse_char(r.ch, r.last, res)) begin
				if (r.typed) begin
					res.value = r.value;
					res.status = r.status;
					res.position = r.position;
				end
				pending_sizes.push_back(res);
			end
		end

		// random segments; each takes its idling mix from a four-entry schedule and, after the first, writes a new limit
		for (int seg = 0; seg < 6; seg++) begin
			if (seg > 0) begin
				drain();
				case (seg)
					1: apb_write(REG_SIZE_LIMIT, 64'd0);
					2: apb_write(REG_SIZE_LIMIT, 64'd1 << $urandom_range(10, 40));
					3: apb_write(REG_SIZE_LIMIT, ALL_ONES);
					4: apb_write(REG_SIZE_LIMIT, {$urandom, $urandom});
					default: apb_write(REG_SIZE_LIMIT, 64'd1000000);
				endcase
			end
			gap_pct = gap_sched[seg % 4];
			stall_pct = stall_sched[seg % 4];
			seg_items = 0;
			while (seg_items < SEG_ITEMS) begin
				build_text();
				send_text();
			end
		end

		drain();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
